// ===== rtl/frm_pkg.sv =====
// Shared types and constants of the frame rate meter.
package frm_pkg;

  localparam int unsigned TIME_W  = 63;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W   = 16;

  // Seconds = (t >> 9) / 5^9, since 1e9 = 2^9 * 5^9.
  localparam int unsigned NS_SHIFT   = 9;
  localparam int unsigned DIVISOR    = 1953125;
  localparam int unsigned DIVIDEND_W = TIME_W - NS_SHIFT;
  localparam int unsigned REM_W      = 21;
  localparam int unsigned SEC_W      = 34;
  localparam int unsigned DIV_STEPS  = 6;
  localparam int unsigned DIV_STAGES = DIVIDEND_W / DIV_STEPS;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [COUNT_W-1:0] ZERO_LIMIT_RST = 16'd120;
  localparam logic [COUNT_W-1:0] MIN_LINES_RST  = 16'd5;

  localparam logic CMD_REPORT = 1'b1;

  localparam logic CFG_ZERO_LIMIT = 1'b0;
  localparam logic CFG_MIN_LINES  = 1'b1;

  typedef enum logic [2:0] {
    DEC_NEW     = 3'd0,
    DEC_EMPTIES = 3'd1,
    DEC_FEW     = 3'd2,
    DEC_HELD    = 3'd3,
    DEC_NONE    = 3'd4
  } decision_e;

  typedef struct packed {
    logic              report;
    logic              empty;
    logic [TIME_W-1:0] frame_time;
    logic [SEC_W-1:0]  frame_sec;
  } item_t;

endpackage

// ===== rtl/frame_rate_meter_core.sv =====
// A report passes the nine-stage seconds divider, the FIFO and the result register.
// Throughput: one item per cycle unless the FIFO is full or a report waits on the result register.
// A report stalls at the FIFO head while the previous result is held in the output register and not drained.
// Reset (async, active low) clears the window, batch counters, queue and pipeline,
// and loads zero_limit = 120, min_lines = 5.
module frame_rate_meter_core #(
  parameter int unsigned QUEUE_DEPTH = frm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [frm_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [62:0]                 frame_time_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [15:0]                 frames_per_second_o,
  output logic [2:0]                  decision_o
);
  import frm_pkg::*;

  item_t front_item, back_item;
  logic  front_valid, front_ready;
  logic  back_valid, back_ready;

  frm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .frame_time_i (frame_time_i),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  frm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  frm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .item_valid_i        (back_valid),
    .item_ready_o        (back_ready),
    .item_i              (back_item),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .frames_per_second_o (frames_per_second_o),
    .decision_o          (decision_o)
  );

endmodule

// ===== rtl/frm_front.sv =====
// Front end: accepts items, classifies them and divides the timestamp into seconds.
module frm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            command_i,
  input  logic [62:0]     frame_time_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output frm_pkg::item_t  item_o
);
  import frm_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [DIVIDEND_W-1:0] num;
  } div_t;

  localparam int unsigned LAST = DIV_STAGES - 1;

  // Restoring division, DIV_STEPS quotient bits per stage; quotient shifts into num.
  function automatic div_t div_steps(input div_t x);
    div_t          y;
    logic [REM_W:0] rs;
    y = x;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rs    = {y.rem, y.num[DIVIDEND_W-1]};
      y.num = {y.num[DIVIDEND_W-2:0], 1'b0};
      if (rs >= (REM_W+1)'(DIVISOR)) begin
        rs       = rs - (REM_W+1)'(DIVISOR);
        y.num[0] = 1'b1;
      end
      y.rem = rs[REM_W-1:0];
    end
    return y;
  endfunction

  logic [DIV_STAGES-1:0] v_q;
  div_t                  div_q   [DIV_STAGES];
  logic                  rep_q   [DIV_STAGES];
  logic                  empty_q [DIV_STAGES];
  logic [TIME_W-1:0]     t_q     [DIV_STAGES];
  logic                  adv;
  div_t                  div_in;

  // Whole pipeline advances unless the last stage is blocked.
  assign adv        = !v_q[LAST] || item_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    div_in.rem = '0;
    div_in.num = frame_time_i[TIME_W-1:NS_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[DIV_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0]   <= div_steps(div_in);
      rep_q[0]   <= (command_i == CMD_REPORT);
      empty_q[0] <= (frame_time_i == '0);
      t_q[0]     <= frame_time_i;
      for (int s = 1; s < DIV_STAGES; s++) begin
        div_q[s]   <= div_steps(div_q[s-1]);
        rep_q[s]   <= rep_q[s-1];
        empty_q[s] <= empty_q[s-1];
        t_q[s]     <= t_q[s-1];
      end
    end
  end

  assign item_valid_o = v_q[LAST];

  always_comb begin
    item_o.report     = rep_q[LAST];
    item_o.empty      = empty_q[LAST];
    item_o.frame_time = t_q[LAST];
    item_o.frame_sec  = div_q[LAST].num[SEC_W-1:0];
  end

endmodule

// ===== rtl/frm_queue.sv =====
// Short FIFO between the front end and the back end.
module frm_queue #(
  parameter int unsigned DEPTH = frm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  frm_pkg::item_t  push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output frm_pkg::item_t  pop_item_o
);
  import frm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ===== rtl/frm_back.sv =====
// Back end: window and batch state, report rules and result register.
module frm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [frm_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           item_valid_i,
  output logic                           item_ready_o,
  input  frm_pkg::item_t                 item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [frm_pkg::COUNT_W-1:0]    frames_per_second_o,
  output logic [2:0]                     decision_o
);
  import frm_pkg::*;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  logic [COUNT_W-1:0] zero_limit_q, min_lines_q;

  logic               win_valid_q, win_valid_d;
  logic [TIME_W-1:0]  win_time_q, win_time_d;
  logic [SEC_W-1:0]   win_sec_q, win_sec_d;
  logic [TIME_W-1:0]  newest_time_q, newest_time_d;
  logic [SEC_W-1:0]   newest_sec_q, newest_sec_d;
  logic [COUNT_W-1:0] queued_q, queued_d;
  logic [COUNT_W-1:0] completed_q, completed_d;
  logic               rollover_q, rollover_d;
  logic               accepted_q, accepted_d;
  logic [COUNT_W-1:0] entry_cnt_q, entry_cnt_d;
  logic [COUNT_W-1:0] empty_cnt_q, empty_cnt_d;
  logic [COUNT_W-1:0] prev_rate_q, prev_rate_d;

  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] fps_q, fps_d;
  decision_e          dec_q, dec_d;

  logic               pop;
  logic [SEC_W-1:0]   ws;
  logic [SEC_W:0]     ws_next;
  logic [SEC_W:0]     fs;
  logic [COUNT_W-1:0] queued_eff;

  // A report waits until the result register is free or being drained.
  assign item_ready_o = !item_i.report || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  assign ws      = win_valid_q ? win_sec_q : '0;
  assign ws_next = {1'b0, ws} + 1'b1;
  assign fs      = {1'b0, item_i.frame_sec};

  always_comb begin
    win_valid_d   = win_valid_q;
    win_time_d    = win_time_q;
    win_sec_d     = win_sec_q;
    newest_time_d = newest_time_q;
    newest_sec_d  = newest_sec_q;
    queued_d      = queued_q;
    completed_d   = completed_q;
    rollover_d    = rollover_q;
    accepted_d    = accepted_q;
    entry_cnt_d   = entry_cnt_q;
    empty_cnt_d   = empty_cnt_q;
    prev_rate_d   = prev_rate_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    fps_d         = fps_q;
    dec_d         = dec_q;
    queued_eff    = queued_q;

    if (pop && !item_i.report) begin
      entry_cnt_d = sat_inc(entry_cnt_q);
      if (item_i.empty) begin
        empty_cnt_d = sat_inc(empty_cnt_q);
      end else if (win_valid_q && (win_time_q >= item_i.frame_time)) begin
        // Time did not advance: drop the window
        win_valid_d = 1'b0;
      end else begin
        accepted_d = 1'b1;
        if (fs == {1'b0, ws}) begin
          queued_d      = sat_inc(queued_q);
          newest_time_d = item_i.frame_time;
          newest_sec_d  = item_i.frame_sec;
        end else if (fs >= ws_next) begin
          rollover_d    = 1'b1;
          win_valid_d   = 1'b1;
          win_time_d    = item_i.frame_time;
          win_sec_d     = item_i.frame_sec;
          queued_d      = COUNT_W'(1);
          newest_time_d = item_i.frame_time;
          newest_sec_d  = item_i.frame_sec;
          if (fs == ws_next) begin
            completed_d = queued_q;
          end
        end
      end
    end else if (pop) begin
      out_valid_d = 1'b1;
      if (empty_cnt_q >= zero_limit_q) begin
        queued_eff = '0;
        fps_d      = '0;
        dec_d      = DEC_EMPTIES;
      end else if (entry_cnt_q < min_lines_q) begin
        fps_d = prev_rate_q;
        dec_d = DEC_FEW;
      end else if (completed_q != '0) begin
        fps_d       = completed_q;
        prev_rate_d = completed_q;
        dec_d       = DEC_NEW;
      end else if (accepted_q && !rollover_q) begin
        fps_d = prev_rate_q;
        dec_d = DEC_HELD;
      end else begin
        fps_d = '0;
        dec_d = DEC_NONE;
      end
      // Start a new batch; the window resumes at the newest queued frame if any frames remain queued
      queued_d    = queued_eff;
      entry_cnt_d = '0;
      empty_cnt_d = '0;
      completed_d = '0;
      rollover_d  = 1'b0;
      accepted_d  = 1'b0;
      win_valid_d = (queued_eff != '0);
      win_time_d  = newest_time_q;
      win_sec_d   = newest_sec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_limit_q <= ZERO_LIMIT_RST;
      min_lines_q  <= MIN_LINES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ZERO_LIMIT: zero_limit_q <= cfg_wdata_i;
        CFG_MIN_LINES:  min_lines_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q   <= 1'b0;
      win_time_q    <= '0;
      win_sec_q     <= '0;
      newest_time_q <= '0;
      newest_sec_q  <= '0;
      queued_q      <= '0;
      completed_q   <= '0;
      rollover_q    <= 1'b0;
      accepted_q    <= 1'b0;
      entry_cnt_q   <= '0;
      empty_cnt_q   <= '0;
      prev_rate_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      win_valid_q   <= win_valid_d;
      win_time_q    <= win_time_d;
      win_sec_q     <= win_sec_d;
      newest_time_q <= newest_time_d;
      newest_sec_q  <= newest_sec_d;
      queued_q      <= queued_d;
      completed_q   <= completed_d;
      rollover_q    <= rollover_d;
      accepted_q    <= accepted_d;
      entry_cnt_q   <= entry_cnt_d;
      empty_cnt_q   <= empty_cnt_d;
      prev_rate_q   <= prev_rate_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fps_q <= fps_d;
    dec_q <= dec_d;
  end

  assign out_valid_o         = out_valid_q;
  assign frames_per_second_o = fps_q;
  assign decision_o          = dec_q;

  a_empty_le_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_cnt_q <= entry_cnt_q)
    else $error("empty count exceeds entry count");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && item_i.report |=> entry_cnt_q == '0 && empty_cnt_q == '0 && completed_q == '0)
    else $error("batch counters not cleared after report");

  a_new_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dec_q == DEC_NEW |-> fps_q != '0 && fps_q == prev_rate_q)
    else $error("new rate result inconsistent");

endmodule
